@@ rtl/hsd_pkg.sv @@
// Package: shared types and constants for the Huffman stream decoder.
package hsd_pkg;
	localparam int unsigned MAX_SYMBOLS_DEF = 256;
	localparam logic [1:0] KIND_SYM  = 2'd0;
	localparam logic [1:0] KIND_EOF  = 2'd1;
	localparam logic [1:0] KIND_INC  = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	typedef enum logic [4:0] {
		PH_PAD   = 5'b00001,
		PH_COUNT = 5'b00010,
		PH_TREE  = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_DRAIN = 5'b10000
	} phase_t;
endpackage

@@ rtl/huffman_stream_decoder_core.sv @@
// Huffman stream decoder top level: header parse, tree build and bit-serial walk.
//
// Input channel: byte_in with last_byte, qualified by in_valid / in_stall.
// Output channel: symbol, kind, last_of_run, qualified by out_valid / out_stall.
// A byte is a transfer when in_valid is high and in_stall low. Pad and count
// bytes are decoded as they transfer. A tree or data byte is held and its bits are
// walked MSB first by one sequencer that reads the node stack and child table;
// a pop in the tree runs through sub-steps and writes both in its last one
// (read right, read left, write). Bits after the header completes are skipped.
// A data symbol is held until the next symbol of the byte or the end of the
// bit walk, so it can carry last_of_run; a final step hands out the held
// symbol, and after it the end-of-file or header-cut-short status of a final
// byte. in_stall stays high while a byte is worked on and while the output
// register holds a result that the receiver stalls; a stall on the output
// holds the sequencer on the bit that needs the register. Kind is 0 for a
// symbol, 1 end of file, 2 header cut short, 3 bad header. After the final
// byte the block returns to its reset state. Reset clears all control state;
// the node stack and child table are memories read only after they are written.
module huffman_stream_decoder_core #(
	parameter int unsigned MAX_SYMBOLS = hsd_pkg::MAX_SYMBOLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] symbol,
	output logic [1:0] kind,
	output logic       last_of_run
);
	import hsd_pkg::*;

	phase_t      phase_q;
	logic        busy_q;      // working through bits of held byte
	logic        fin_q;       // final status step pending
	logic [7:0]  byte_q;
	logic        last_q;
	logic [2:0]  bit_q;       // current bit index (MSB first)
	logic        got_q;       // some result produced for this byte
	logic [2:0]  pad_q;
	logic [8:0]  sym_exp_q;
	logic [8:0]  leaves_q;
	logic [8:0]  depth_q;
	logic [7:0]  icount_q;
	logic [8:0]  root_q;
	logic [8:0]  walk_q;
	logic [7:0]  lshift_q;
	logic [3:0]  lbits_q;
	// pop sub-steps: 0 read right, 1 read left, 2 write
	logic [1:0]  pop_q;
	logic [8:0]  right_q;
	logic        pend_q;      // decoded symbol held back
	logic [7:0]  pend_sym_q;

	logic [8:0]  stack_mem [256];
	logic [17:0] child_mem [256];
	logic [8:0]  stack_rd_q;
	logic [17:0] child_rd_q;

	logic        ov_q;
	logic [7:0]  sym_q;
	logic [1:0]  kind_q;
	logic        lor_q;

	logic out_free;
	assign out_free = !ov_q || !out_stall;

	assign out_valid   = ov_q;
	assign symbol      = sym_q;
	assign kind        = kind_q;
	assign last_of_run = lor_q;
	assign in_stall    = busy_q | fin_q | !out_free;

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	logic cur_bit;
	assign cur_bit = byte_q[bit_q];

	logic [2:0] lo_bit;
	assign lo_bit = last_q ? pad_q : 3'd0;

	logic [9:0] cnt_plus;
	assign cnt_plus = {2'b00, byte_in} + 10'd1;

	// stack / child-table access signals
	logic        st_we;
	logic [7:0]  st_wa;
	logic [8:0]  st_wd;
	logic [7:0]  st_ra;
	logic        ct_we;
	logic [7:0]  ct_wa;
	logic [17:0] ct_wd;
	logic [7:0]  ct_ra;

	always_ff @(posedge clk) begin
		if (st_we) stack_mem[st_wa] <= st_wd;
		stack_rd_q <= stack_mem[st_ra];
		if (ct_we) child_mem[ct_wa] <= ct_wd;
		child_rd_q <= child_mem[ct_ra];
	end

	// next-state comb
	phase_t      phase_d;
	logic        busy_d, fin_d, got_d, last_d;
	logic [2:0]  bit_d, pad_d;
	logic [7:0]  byte_d;
	logic [8:0]  sym_exp_d, leaves_d, depth_d, root_d, walk_d, right_d;
	logic [7:0]  icount_d, lshift_d;
	logic [3:0]  lbits_d;
	logic [1:0]  pop_d;
	logic        pend_d;
	logic [7:0]  pend_sym_d;
	logic        emit;
	logic [7:0]  emit_sym;
	logic [1:0]  emit_kind;
	logic        emit_last;
	logic        advance;     // bit consumed
	logic        stop_bits;   // leave bit loop early
	logic        do_clear;
	logic [8:0]  new_leaf;
	logic [8:0]  nxt;

	always_comb begin
		phase_d = phase_q; busy_d = busy_q; fin_d = fin_q; got_d = got_q;
		last_d = last_q; bit_d = bit_q; pad_d = pad_q; byte_d = byte_q;
		sym_exp_d = sym_exp_q; leaves_d = leaves_q; depth_d = depth_q;
		root_d = root_q; walk_d = walk_q; right_d = right_q;
		icount_d = icount_q; lshift_d = lshift_q; lbits_d = lbits_q;
		pop_d = pop_q; pend_d = pend_q; pend_sym_d = pend_sym_q;
		emit = 1'b0; emit_sym = 8'd0; emit_kind = KIND_SYM; emit_last = 1'b0;
		advance = 1'b0; stop_bits = 1'b0; do_clear = 1'b0;
		st_we = 1'b0; st_wa = depth_q[7:0]; st_wd = 9'd0; st_ra = 8'd0;
		ct_we = 1'b0; ct_wa = icount_q; ct_wd = 18'd0; ct_ra = walk_q[7:0];
		new_leaf = {1'b1, lshift_q[6:0], cur_bit};
		nxt = cur_bit ? child_rd_q[8:0] : child_rd_q[17:9];

		if (in_xfer) begin
			byte_d = byte_in; last_d = last_byte; got_d = 1'b0;
			case (phase_q)
				PH_PAD: begin
					if (byte_in > 8'd7) begin
						emit = 1'b1; emit_kind = KIND_BAD; emit_last = 1'b1;
						if (last_byte) do_clear = 1'b1;
						else phase_d = PH_DRAIN;
					end else begin
						pad_d = byte_in[2:0]; phase_d = PH_COUNT;
						if (last_byte) begin
							emit = 1'b1; emit_kind = KIND_INC; emit_last = 1'b1;
							do_clear = 1'b1;
						end
					end
				end
				PH_COUNT: begin
					if (cnt_plus > 10'(MAX_SYMBOLS)) begin
						emit = 1'b1; emit_kind = KIND_BAD; emit_last = 1'b1;
						if (last_byte) do_clear = 1'b1;
						else phase_d = PH_DRAIN;
					end else begin
						sym_exp_d = cnt_plus[8:0]; phase_d = PH_TREE;
						if (last_byte) begin
							emit = 1'b1; emit_kind = KIND_INC; emit_last = 1'b1;
							do_clear = 1'b1;
						end
					end
				end
				PH_TREE: begin
					busy_d = 1'b1; bit_d = 3'd7; pop_d = 2'd0;
				end
				PH_DATA: begin
					busy_d = 1'b1; bit_d = 3'd7;
				end
				PH_DRAIN: begin
					if (last_byte) do_clear = 1'b1;
				end
				default: ;
			endcase
		end else if (fin_q) begin
			if (out_free) begin
				if (pend_q) begin
					// held symbol closes the byte unless end of file follows
					emit = 1'b1; emit_sym = pend_sym_q; emit_last = !last_q;
					pend_d = 1'b0; fin_d = last_q;
				end else begin
					fin_d = 1'b0;
					if (phase_q == PH_DATA || got_q) begin
						if (phase_q == PH_DATA) begin
							emit = 1'b1; emit_kind = KIND_EOF; emit_last = 1'b1;
						end
					end else begin
						emit = 1'b1; emit_kind = KIND_INC; emit_last = 1'b1;
					end
					do_clear = 1'b1;
				end
			end
		end else if (busy_q && phase_q == PH_TREE) begin
			if (lbits_q != 4'd0) begin
				lshift_d = {lshift_q[6:0], cur_bit};
				lbits_d = lbits_q - 4'd1;
				if (lbits_q == 4'd1) begin
					if (depth_q[8]) begin
						emit = 1'b1; emit_kind = KIND_BAD; stop_bits = 1'b1;
					end else begin
						st_we = 1'b1; st_wd = new_leaf;
						depth_d = depth_q + 9'd1;
						leaves_d = leaves_q + 9'd1;
						if (leaves_q + 9'd1 == sym_exp_q && depth_q == 9'd0) begin
							root_d = new_leaf;
							emit = 1'b1; emit_kind = KIND_BAD; stop_bits = 1'b1;
						end else advance = 1'b1;
					end
				end else advance = 1'b1;
			end else if (pop_q == 2'd0 && cur_bit) begin
				if (leaves_q >= sym_exp_q) begin
					emit = 1'b1; emit_kind = KIND_BAD; stop_bits = 1'b1;
				end else begin
					lbits_d = 4'd8; lshift_d = 8'd0; advance = 1'b1;
				end
			end else begin
				case (pop_q)
					2'd0: begin
						if (depth_q < 9'd2 || icount_q == 8'd255) begin
							emit = 1'b1; emit_kind = KIND_BAD; stop_bits = 1'b1;
						end else begin
							st_ra = 8'(depth_q - 9'd1); pop_d = 2'd1;
						end
					end
					2'd1: begin
						right_d = stack_rd_q;
						st_ra = 8'(depth_q - 9'd2); pop_d = 2'd2;
					end
					default: begin
						ct_we = 1'b1; ct_wd = {stack_rd_q, right_q};
						st_we = 1'b1; st_wa = 8'(depth_q - 9'd2);
						st_wd = {1'b0, icount_q};
						icount_d = icount_q + 8'd1;
						depth_d = depth_q - 9'd1;
						pop_d = 2'd0;
						if (leaves_q == sym_exp_q && depth_q == 9'd2) begin
							root_d = {1'b0, icount_q}; walk_d = {1'b0, icount_q};
							depth_d = 9'd0;
							phase_d = PH_DATA; stop_bits = 1'b1;
						end else advance = 1'b1;
					end
				endcase
			end
			if (emit && !out_free) begin
				// hold everything until the output register frees
				phase_d = phase_q; lshift_d = lshift_q; lbits_d = lbits_q;
				depth_d = depth_q; leaves_d = leaves_q; root_d = root_q;
				st_we = 1'b0; emit = 1'b0; stop_bits = 1'b0;
			end else if (emit) begin
				phase_d = PH_DRAIN; got_d = 1'b1;
				emit_last = !last_q;
				if (last_q) emit_last = 1'b1;
			end
			if (advance && bit_q == 3'd0) stop_bits = 1'b1;
			if (advance) bit_d = bit_q - 3'd1;
			if (stop_bits) begin
				busy_d = 1'b0;
				if (last_q) begin
					if (emit) do_clear = 1'b1;
					else fin_d = 1'b1;
				end
			end
		end else if (busy_q && phase_q == PH_DATA) begin
			// a second symbol in the byte pushes the held one out
			if (!(nxt[8] && pend_q) || out_free) begin
				if (nxt[8]) begin
					if (pend_q) begin
						emit = 1'b1; emit_sym = pend_sym_q;
					end
					pend_d = 1'b1; pend_sym_d = nxt[7:0]; got_d = 1'b1;
					walk_d = root_q;
				end else walk_d = nxt;
				ct_ra = nxt[8] ? root_q[7:0] : nxt[7:0];
				bit_d = bit_q - 3'd1;
				if (bit_q == lo_bit) begin
					busy_d = 1'b0;
					if (last_q || pend_d) fin_d = 1'b1;
				end
			end
		end
		if (do_clear) begin
			phase_d = PH_PAD; busy_d = 1'b0; fin_d = 1'b0;
			pad_d = 3'd0; sym_exp_d = 9'd0; leaves_d = 9'd0; depth_d = 9'd0;
			icount_d = 8'd0; root_d = 9'd0; walk_d = 9'd0; lshift_d = 8'd0;
			lbits_d = 4'd0; pop_d = 2'd0; pend_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PAD; busy_q <= 1'b0; fin_q <= 1'b0; got_q <= 1'b0;
			last_q <= 1'b0; bit_q <= 3'd0; pad_q <= 3'd0; byte_q <= 8'd0;
			sym_exp_q <= 9'd0; leaves_q <= 9'd0; depth_q <= 9'd0;
			root_q <= 9'd0; walk_q <= 9'd0; right_q <= 9'd0; icount_q <= 8'd0;
			lshift_q <= 8'd0; lbits_q <= 4'd0; pop_q <= 2'd0;
			pend_q <= 1'b0; pend_sym_q <= 8'd0;
			ov_q <= 1'b0; sym_q <= 8'd0; kind_q <= KIND_SYM; lor_q <= 1'b0;
		end else begin
			phase_q <= phase_d; busy_q <= busy_d; fin_q <= fin_d; got_q <= got_d;
			last_q <= last_d; bit_q <= bit_d; pad_q <= pad_d; byte_q <= byte_d;
			sym_exp_q <= sym_exp_d; leaves_q <= leaves_d; depth_q <= depth_d;
			root_q <= root_d; walk_q <= walk_d; right_q <= right_d;
			icount_q <= icount_d; lshift_q <= lshift_d; lbits_q <= lbits_d;
			pop_q <= pop_d; pend_q <= pend_d; pend_sym_q <= pend_sym_d;
			if (emit) begin
				ov_q <= 1'b1; sym_q <= emit_sym; kind_q <= emit_kind;
				lor_q <= emit_last;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule
